// ===== sv/mission_sequencer_with_retries_unit_assert.svh =====
// Assertion macros shared by the mission sequencer RTL.
`ifndef MISSION_SEQUENCER_WITH_RETRIES_UNIT_ASSERT_SVH
`define MISSION_SEQUENCER_WITH_RETRIES_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MSR_ASSERT_IMPL(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MSR_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== sv/msr_pkg.sv =====
// Types, codes and helpers shared by the mission sequencer modules.
package msr_pkg;

   localparam logic [7:0] MAX_SEGMENTS = 8'd255;

   typedef enum logic [2:0] {
      CMD_TICK    = 3'd0,
      CMD_BATTERY = 3'd1,
      CMD_START   = 3'd2,
      CMD_COVER   = 3'd3,
      CMD_NAV     = 3'd4,
      CMD_FOLLOW  = 3'd5,
      CMD_DOCK    = 3'd6,
      CMD_RETRY   = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_REQ  = 3'd1,
      MODE_NAV  = 3'd2,
      MODE_MOW  = 3'd3,
      MODE_RET  = 3'd4,
      MODE_CHG  = 3'd5,
      MODE_ERR  = 3'd6
   } mode_type;

   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_COVER     = 3'd1,
      ACT_NAV       = 3'd2,
      ACT_FOLLOW    = 3'd3,
      ACT_DOCK      = 3'd4,
      ACT_CNAV_DOCK = 3'd5,
      ACT_CFOL_DOCK = 3'd6,
      ACT_RETRY     = 3'd7
   } act_type;

   typedef enum logic [2:0] {
      CSR_BATT_LOW  = 3'd0,
      CSR_BATT_FULL = 3'd1,
      CSR_AUTO      = 3'd2,
      CSR_AREA      = 3'd3,
      CSR_RETRIES   = 3'd4
   } csr_idx_type;

   localparam logic [6:0] BATT_LOW_RST  = 7'd30;
   localparam logic [6:0] BATT_FULL_RST = 7'd95;
   localparam logic [3:0] RETRIES_RST   = 4'd3;

   typedef struct packed {
      logic [6:0] battery_low_level;
      logic [6:0] battery_full_level;
      logic       auto_start;
      logic       area_configured;
      logic [3:0] max_retries;
   } cfg_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [6:0] battery_level;
      logic       success;
      logic       server_ready;
      logic [7:0] segment_count;
   } item_type;

   typedef struct packed {
      mode_type   mode;
      logic [6:0] battery_now;
      logic       coverage_pending;
      logic       follow_busy;
      logic       dock_busy;
      logic [3:0] navigate_tries;
      logic [3:0] follow_tries;
      logic [3:0] dock_tries;
      logic [7:0] segment_position;
      logic [7:0] segment_total;
   } state_type;

   typedef struct packed {
      logic       start_accepted;
      logic [7:0] segment_index;
      act_type    action;
      mode_type   mission_state;
   } result_type;

   // Failure count plus one, saturated to the 4-bit counter.
   function automatic logic [3:0] sat_tries(logic [4:0] n);
      return (n > 5'd15) ? 4'd15 : n[3:0];
   endfunction

endpackage

// ===== sv/msr_csr.sv =====
// Configuration register file of the mission sequencer.
module msr_csr
   import msr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [2:0] csr_addr,
   input  logic [6:0] csr_wdata,
   output cfg_type    cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.battery_low_level  <= BATT_LOW_RST;
         cfg_ff.battery_full_level <= BATT_FULL_RST;
         cfg_ff.auto_start         <= 1'b1;
         cfg_ff.area_configured    <= 1'b0;
         cfg_ff.max_retries        <= RETRIES_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_BATT_LOW:  cfg_ff.battery_low_level  <= csr_wdata;
            CSR_BATT_FULL: cfg_ff.battery_full_level <= csr_wdata;
            CSR_AUTO:      cfg_ff.auto_start         <= csr_wdata[0];
            CSR_AREA:      cfg_ff.area_configured    <= csr_wdata[0];
            CSR_RETRIES:   cfg_ff.max_retries        <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/msr_step.sv =====
// Event decision logic: next mission state and result for one event.
module msr_step
   import msr_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  st,
   input  item_type   item,
   output state_type  st_in,
   output result_type res
);

   logic       low;
   logic [4:0] nav_n;
   logic [4:0] fol_n;
   logic [4:0] dock_n;
   logic [4:0] max_n;
   logic [8:0] pos_n;
   logic [7:0] seg_n;
   act_type    act;
   act_type    dock_act;

   assign low    = st.battery_now <= cfg.battery_low_level;
   assign nav_n  = {1'b0, st.navigate_tries} + 5'd1;
   assign fol_n  = {1'b0, st.follow_tries} + 5'd1;
   assign dock_n = {1'b0, st.dock_tries} + 5'd1;
   assign max_n  = {1'b0, cfg.max_retries};
   assign pos_n  = {1'b0, st.segment_position} + 9'd1;
   assign seg_n  = (item.segment_count > MAX_SEGMENTS) ? MAX_SEGMENTS : item.segment_count;

   always_comb begin
      st_in    = st;
      act      = ACT_NONE;
      dock_act = st.follow_busy ? ACT_CFOL_DOCK : ACT_DOCK;
      res.start_accepted = 1'b0;
      case (item.cmd)
         CMD_TICK: begin
            case (st.mode)
               MODE_IDLE: begin
                  if (cfg.auto_start && cfg.area_configured) st_in.mode = MODE_REQ;
               end
               MODE_REQ: begin
                  if (!st.coverage_pending && item.server_ready) begin
                     st_in.coverage_pending = 1'b1;
                     act = ACT_COVER;
                  end
               end
               MODE_NAV, MODE_MOW: begin
                  if (low && !st.dock_busy) begin
                     st_in.follow_busy = 1'b0;
                     if (item.server_ready) begin
                        st_in.mode      = MODE_RET;
                        st_in.dock_busy = 1'b1;
                        act = (st.mode == MODE_NAV) ? ACT_CNAV_DOCK : dock_act;
                     end else begin
                        st_in.mode = MODE_ERR;
                     end
                     // navigating leaves follow_busy alone
                     if (st.mode == MODE_NAV) st_in.follow_busy = st.follow_busy;
                  end
               end
               MODE_CHG: begin
                  if (st.battery_now >= cfg.battery_full_level) st_in.mode = MODE_REQ;
               end
               default: ;
            endcase
         end
         CMD_BATTERY: st_in.battery_now = item.battery_level;
         CMD_START: begin
            if (st.mode == MODE_IDLE || st.mode == MODE_ERR) begin
               res.start_accepted = 1'b1;
               st_in.mode = MODE_REQ;
               if (!st.coverage_pending && item.server_ready) begin
                  st_in.coverage_pending = 1'b1;
                  act = ACT_COVER;
               end
            end
         end
         CMD_COVER: begin
            if (st.coverage_pending) begin
               st_in.coverage_pending = 1'b0;
               if (item.success) begin
                  if (seg_n == 8'd0) begin
                     st_in.mode = MODE_ERR;
                  end else begin
                     st_in.segment_total    = seg_n;
                     st_in.segment_position = 8'd0;
                     st_in.navigate_tries   = 4'd0;
                     if (item.server_ready) begin
                        st_in.mode = MODE_NAV;
                        act = ACT_NAV;
                     end else begin
                        st_in.mode = MODE_ERR;
                     end
                  end
               end
            end
         end
         CMD_NAV: begin
            if (st.mode == MODE_NAV) begin
               if (item.success) begin
                  st_in.navigate_tries = 4'd0;
                  if (item.server_ready) begin
                     st_in.mode = MODE_MOW;
                     st_in.follow_busy = 1'b1;
                     act = ACT_FOLLOW;
                  end else begin
                     st_in.mode = MODE_ERR;
                  end
               end else begin
                  st_in.navigate_tries = sat_tries(nav_n);
                  if (nav_n > max_n) st_in.mode = MODE_ERR;
                  else act = ACT_RETRY;
               end
            end
         end
         CMD_FOLLOW: begin
            st_in.follow_busy = 1'b0;
            if (st.mode == MODE_MOW) begin
               if (item.success) begin
                  st_in.follow_tries     = 4'd0;
                  st_in.segment_position = pos_n[8] ? 8'd255 : pos_n[7:0];
                  if (!item.server_ready) begin
                     st_in.mode = MODE_ERR;
                     if (pos_n < {1'b0, st.segment_total}) st_in.navigate_tries = 4'd0;
                  end else if (pos_n >= {1'b0, st.segment_total}) begin
                     st_in.mode      = MODE_RET;
                     st_in.dock_busy = 1'b1;
                     act = ACT_DOCK;
                  end else begin
                     st_in.navigate_tries = 4'd0;
                     st_in.mode = MODE_NAV;
                     act = ACT_NAV;
                  end
               end else begin
                  st_in.follow_tries = sat_tries(fol_n);
                  if (fol_n > max_n) st_in.mode = MODE_ERR;
                  else act = ACT_RETRY;
               end
            end
         end
         CMD_DOCK: begin
            st_in.dock_busy = 1'b0;
            if (item.success) begin
               st_in.dock_tries = 4'd0;
               st_in.mode = MODE_CHG;
            end else if (st.mode == MODE_RET) begin
               st_in.dock_tries = sat_tries(dock_n);
               if (dock_n > max_n) st_in.mode = MODE_ERR;
               else act = ACT_RETRY;
            end
         end
         CMD_RETRY: begin
            if (st.mode == MODE_NAV || st.mode == MODE_MOW || st.mode == MODE_RET) begin
               if (!item.server_ready) begin
                  st_in.mode = MODE_ERR;
               end else if (st.mode == MODE_NAV) begin
                  act = ACT_NAV;
               end else if (st.mode == MODE_MOW) begin
                  st_in.follow_busy = 1'b1;
                  act = ACT_FOLLOW;
               end else begin
                  st_in.dock_busy = 1'b1;
                  act = ACT_DOCK;
               end
            end
         end
         default: ;
      endcase
      res.action        = act;
      res.mission_state = st_in.mode;
      res.segment_index = st_in.segment_position;
   end

endmodule

// ===== sv/mission_sequencer_with_retries_unit.sv =====
// Mission sequencer top level: event register, decision logic, result register.
// Pipeline: a transaction accepted on req_ is captured in the input register, then passes
//   the decision logic into the result register, which drives rsp_.
// Throughput: one event per cycle, limited only by rsp_tready backpressure.
// Reset (synchronous, active high) empties both stages, clears the mission state
//   to idle and zero, and loads the configuration registers with their defaults.
`include "mission_sequencer_with_retries_unit_assert.svh"
module mission_sequencer_with_retries_unit
   import msr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // cmd
   // battery_level[6:0], success[7], server_ready[8], segment_count[16:9], zero[23:17]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // mission_state[2:0], action[5:3], segment_index[13:6], start_accepted[14], zero[15]
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [6:0]  csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff;
   logic       item_valid_ff;
   state_type  st_ff;
   state_type  st_in;
   result_type res_in;
   result_type res_ff;
   logic       rsp_valid_ff;
   logic       advance;

   msr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   msr_step u_step (
      .cfg   (cfg),
      .st    (st_ff),
      .item  (item_ff),
      .st_in (st_in),
      .res   (res_in)
   );

   // event moves into the result register when that register is free or draining
   assign advance    = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.cmd           <= cmd_type'(req_tuser);
         item_ff.battery_level <= req_tdata[6:0];
         item_ff.success       <= req_tdata[7];
         item_ff.server_ready  <= req_tdata[8];
         item_ff.segment_count <= req_tdata[16:9];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode             <= MODE_IDLE;
         st_ff.battery_now      <= 7'd0;
         st_ff.coverage_pending <= 1'b0;
         st_ff.follow_busy      <= 1'b0;
         st_ff.dock_busy        <= 1'b0;
         st_ff.navigate_tries   <= 4'd0;
         st_ff.follow_tries     <= 4'd0;
         st_ff.dock_tries       <= 4'd0;
         st_ff.segment_position <= 8'd0;
         st_ff.segment_total    <= 8'd0;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, res_ff};

   `MSR_ASSERT_IMPL(a_start_in_req, rsp_valid_ff && res_ff.start_accepted, res_ff.mission_state == MODE_REQ, "accepted start must leave mission in requesting")
   `MSR_ASSERT_IMPL(a_cover_pending, rsp_valid_ff && res_ff.action == ACT_COVER, st_ff.coverage_pending, "coverage request issued without pending flag")
   `MSR_ASSERT_NEXT(a_item_hold, item_valid_ff && !advance, item_valid_ff, "stalled event dropped from input register")
   `MSR_ASSERT_IMPL(a_follow_busy, rsp_valid_ff && res_ff.action == ACT_FOLLOW, st_ff.follow_busy, "follow issued without busy flag")

endmodule

// ===== verif/mission_sequencer_with_retries_unit_test.sv =====
// Self-checking testbench for the mission sequencer: scripted missions, random events, CSR sweeps.
module mission_sequencer_with_retries_unit_test;
   import msr_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_EVENTS = 200;
   localparam int HOLD_OFF_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser = '0;   // cmd
   // battery_level[6:0], success[7], server_ready[8], segment_count[16:9], zero[23:17]
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // mission_state[2:0], action[5:3], segment_index[13:6], start_accepted[14], zero[15]
   logic [15:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [6:0]  csr_wdata = '0;

   mission_sequencer_with_retries_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow of the CSRs and of the mission state
   cfg_type    csr_shadow;
   mode_type   mow_mode;
   logic [6:0] batt_pct;
   logic       cover_wait, follow_on, dock_on;
   logic [3:0] nav_fails, follow_fails, dock_fails;
   logic [7:0] seg_at, seg_goal;

   item_type   pending_events[$];
   result_type predicted_reports[$];

   int  events_queued = 0;
   int  events_taken = 0;
   int  reports_checked = 0;
   int  fault_count = 0;
   int  settings_run = 0;
   int  cycle_count = 0;
   int  mode_seen[7];
   int  idle_pct = 30;
   int  req_gap = 0;
   int  rsp_gap = 0;
   int  hold_left = 0;
   bit  hold_request = 1'b0;
   bit  req_fired = 1'b0;

   function automatic bit coin(int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int draw_gap(int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic act_type ask_coverage(logic rdy);
      if (cover_wait || !rdy) return ACT_NONE;
      cover_wait = 1'b1;
      return ACT_COVER;
   endfunction

   function automatic act_type send_nav(logic rdy);
      if (!rdy) begin
         mow_mode = MODE_ERR;
         return ACT_NONE;
      end
      return ACT_NAV;
   endfunction

   function automatic act_type send_follow(logic rdy);
      if (!rdy) begin
         mow_mode = MODE_ERR;
         return ACT_NONE;
      end
      follow_on = 1'b1;
      return ACT_FOLLOW;
   endfunction

   function automatic act_type send_dock(logic rdy, act_type act);
      if (!rdy) begin
         mow_mode = MODE_ERR;
         return ACT_NONE;
      end
      dock_on = 1'b1;
      return act;
   endfunction

   // counter saturates at 15; overrunning max_retries drops into error
   function automatic act_type retry_or_fail(input logic [3:0] tries, output logic [3:0] bumped);
      logic [4:0] n;
      n = {1'b0, tries} + 5'd1;
      bumped = (n > 5'd15) ? 4'd15 : n[3:0];
      if (n > {1'b0, csr_shadow.max_retries}) begin
         mow_mode = MODE_ERR;
         return ACT_NONE;
      end
      return ACT_RETRY;
   endfunction

   function automatic result_type advance_mission(item_type ev);
      result_type r;
      act_type    act;
      logic       took;
      logic       low;
      logic [8:0] nxt;
      act = ACT_NONE;
      took = 1'b0;
      low = batt_pct <= csr_shadow.battery_low_level;
      case (ev.cmd)
         CMD_TICK: begin
            case (mow_mode)
               MODE_IDLE: begin
                  if (csr_shadow.auto_start && csr_shadow.area_configured) mow_mode = MODE_REQ;
               end
               MODE_REQ: act = ask_coverage(ev.server_ready);
               MODE_NAV: begin
                  if (low && !dock_on) begin
                     mow_mode = MODE_RET;
                     act = send_dock(ev.server_ready, ACT_CNAV_DOCK);
                  end
               end
               MODE_MOW: begin
                  if (low && !dock_on) begin
                     act = follow_on ? ACT_CFOL_DOCK : ACT_DOCK;
                     follow_on = 1'b0;
                     mow_mode = MODE_RET;
                     act = send_dock(ev.server_ready, act);
                  end
               end
               MODE_CHG: begin
                  if (batt_pct >= csr_shadow.battery_full_level) mow_mode = MODE_REQ;
               end
               default: ;
            endcase
         end
         CMD_BATTERY: batt_pct = ev.battery_level;
         CMD_START: begin
            if (mow_mode == MODE_IDLE || mow_mode == MODE_ERR) begin
               took = 1'b1;
               mow_mode = MODE_REQ;
               act = ask_coverage(ev.server_ready);
            end
         end
         CMD_COVER: begin
            // replies with nothing outstanding are dropped
            if (cover_wait) begin
               cover_wait = 1'b0;
               if (ev.success) begin
                  if (ev.segment_count == 8'd0) begin
                     mow_mode = MODE_ERR;
                  end else begin
                     seg_goal = ev.segment_count;
                     seg_at = 8'd0;
                     nav_fails = 4'd0;
                     mow_mode = MODE_NAV;
                     act = send_nav(ev.server_ready);
                  end
               end
            end
         end
         CMD_NAV: begin
            if (mow_mode == MODE_NAV) begin
               if (ev.success) begin
                  nav_fails = 4'd0;
                  mow_mode = MODE_MOW;
                  act = send_follow(ev.server_ready);
               end else begin
                  act = retry_or_fail(nav_fails, nav_fails);
               end
            end
         end
         CMD_FOLLOW: begin
            follow_on = 1'b0;
            if (mow_mode == MODE_MOW) begin
               if (ev.success) begin
                  nxt = {1'b0, seg_at} + 9'd1;
                  follow_fails = 4'd0;
                  seg_at = (nxt > 9'd255) ? 8'd255 : nxt[7:0];
                  if (nxt >= {1'b0, seg_goal}) begin
                     mow_mode = MODE_RET;
                     act = send_dock(ev.server_ready, ACT_DOCK);
                  end else begin
                     nav_fails = 4'd0;
                     mow_mode = MODE_NAV;
                     act = send_nav(ev.server_ready);
                  end
               end else begin
                  act = retry_or_fail(follow_fails, follow_fails);
               end
            end
         end
         CMD_DOCK: begin
            dock_on = 1'b0;
            if (ev.success) begin
               dock_fails = 4'd0;
               mow_mode = MODE_CHG;
            end else if (mow_mode == MODE_RET) begin
               act = retry_or_fail(dock_fails, dock_fails);
            end
         end
         default: begin
            // retry timer resends whatever the current state is waiting on
            if (mow_mode == MODE_NAV) act = send_nav(ev.server_ready);
            else if (mow_mode == MODE_MOW) act = send_follow(ev.server_ready);
            else if (mow_mode == MODE_RET) act = send_dock(ev.server_ready, ACT_DOCK);
         end
      endcase
      r.mission_state = mow_mode;
      r.action = act;
      r.segment_index = seg_at;
      r.start_accepted = took;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         fault_count++;
         if (fault_count <= 40)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // sender: holds an item until taken, then pulls the next one after a random gap
   always @(negedge clock) begin
      item_type ev;
      if (!(req_tvalid && !req_fired)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            ev = pending_events.pop_front();
            req_tuser <= ev.cmd;
            req_tdata <= {7'd0, ev.segment_count, ev.server_ready, ev.success, ev.battery_level};
            req_tvalid <= 1'b1;
            req_gap = draw_gap(idle_pct);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap = draw_gap(idle_pct);
      end
   end

   // monitor: check results first, then predict for the transaction taken at this edge
   always @(posedge clock) begin
      result_type got, want;
      item_type   ev;
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[14:0]);
            if (predicted_reports.size() == 0) begin
               fault_count++;
               if (fault_count <= 40)
                  $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
            end else begin
               want = predicted_reports.pop_front();
               check_field("mission_state", want.mission_state, got.mission_state);
               check_field("action", want.action, got.action);
               check_field("segment_index", want.segment_index, got.segment_index);
               check_field("start_accepted", want.start_accepted, got.start_accepted);
               check_field("pad", 8'd0, rsp_tdata[15]);
               reports_checked++;
            end
         end
         req_fired = req_tvalid && req_tready;
         if (req_fired) begin
            ev.cmd = cmd_type'(req_tuser);
            ev.battery_level = req_tdata[6:0];
            ev.success = req_tdata[7];
            ev.server_ready = req_tdata[8];
            ev.segment_count = req_tdata[16:9];
            want = advance_mission(ev);
            mode_seen[want.mission_state]++;
            predicted_reports.insert(predicted_reports.size(), want);
            events_taken++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, predicted_reports.size());
         $display("mission_sequencer_with_retries_unit_test: errors");
         $finish;
      end
   end

   task automatic queue_event(cmd_type c, int lvl, bit ok, bit rdy, int cnt);
      item_type ev;
      ev.cmd = c;
      ev.battery_level = lvl[6:0];
      ev.success = ok;
      ev.server_ready = rdy;
      ev.segment_count = cnt[7:0];
      pending_events.insert(pending_events.size(), ev);
      events_queued++;
   endtask

   // fields that the command does not use get random values
   task automatic queue_step(cmd_type c, bit ok, bit rdy);
      queue_event(c, $urandom_range(0, 127), ok, rdy, $urandom_range(0, 255));
   endtask

   task automatic write_csr(csr_idx_type idx, logic [6:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_BATT_LOW:  csr_shadow.battery_low_level = val;
         CSR_BATT_FULL: csr_shadow.battery_full_level = val;
         CSR_AUTO:      csr_shadow.auto_start = val[0];
         CSR_AREA:      csr_shadow.area_configured = val[0];
         default:       csr_shadow.max_retries = val[3:0];
      endcase
   endtask

   // wait until every queued transaction has been taken and answered
   task automatic drain();
      while (events_taken != events_queued || predicted_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic queue_fail_loop(cmd_type c, int pct);
      int n;
      n = 0;
      while (coin(pct) && n < 4) begin
         queue_step(c, 1'b0, coin(50));
         queue_step(CMD_RETRY, coin(50), coin(97));
         n++;
      end
   endtask

   // one well-formed mission with random detours: failures, retries, low battery, bad replies
   task automatic queue_mission();
      int segs, k;
      bit rdy;
      queue_event(CMD_BATTERY, $urandom_range(60, 127), coin(50), coin(50), $urandom_range(0, 255));
      rdy = coin(90);
      queue_step(CMD_START, coin(50), rdy);
      queue_step(CMD_TICK, coin(50), coin(95));
      queue_step(CMD_TICK, coin(50), 1'b1);
      segs = coin(10) ? $urandom_range(7, 255) : $urandom_range(1, 4);
      if (coin(4)) segs = 0;
      queue_event(CMD_COVER, $urandom_range(0, 127), coin(93), coin(96), segs);
      for (k = 0; k < segs && k < 5; k++) begin
         queue_fail_loop(CMD_NAV, 25);
         queue_step(CMD_NAV, 1'b1, coin(97));
         if (coin(12)) begin
            queue_event(CMD_BATTERY, $urandom_range(0, 35), coin(50), coin(50),
                        $urandom_range(0, 255));
            queue_step(CMD_TICK, coin(50), coin(94));
            queue_fail_loop(CMD_DOCK, 30);
            queue_step(CMD_DOCK, 1'b1, coin(50));
            queue_event(CMD_BATTERY, $urandom_range(95, 127), coin(50), coin(50),
                        $urandom_range(0, 255));
            return;
         end
         queue_fail_loop(CMD_FOLLOW, 25);
         queue_step(CMD_FOLLOW, 1'b1, coin(97));
      end
      if (coin(70)) begin
         queue_fail_loop(CMD_DOCK, 20);
         queue_step(CMD_DOCK, coin(90), coin(50));
      end
   endtask

   task automatic run_phase(int low, int full, bit auto, bit area, int retries, int pct, bit hold);
      int mark;
      write_csr(CSR_BATT_LOW, low[6:0]);
      write_csr(CSR_BATT_FULL, full[6:0]);
      write_csr(CSR_AUTO, {6'd0, auto});
      write_csr(CSR_AREA, {6'd0, area});
      write_csr(CSR_RETRIES, retries[6:0]);
      @(negedge clock);
      csr_we <= 1'b0;
      settings_run++;
      idle_pct = pct;
      mark = events_queued;
      while (events_queued - mark < PHASE_EVENTS) begin
         if (coin(75)) begin
            queue_mission();
         end else begin
            repeat ($urandom_range(1, 3))
               queue_event(cmd_type'($urandom_range(0, 7)), $urandom_range(0, 127), coin(50),
                           coin(50), $urandom_range(0, 255));
         end
      end
      if (hold) hold_request = 1'b1;
      drain();
   endtask

   initial begin
      csr_shadow.battery_low_level = BATT_LOW_RST;
      csr_shadow.battery_full_level = BATT_FULL_RST;
      csr_shadow.auto_start = 1'b1;
      csr_shadow.area_configured = 1'b0;
      csr_shadow.max_retries = RETRIES_RST;
      mow_mode = MODE_IDLE;
      batt_pct = '0;
      cover_wait = 1'b0;
      follow_on = 1'b0;
      dock_on = 1'b0;
      nav_fails = '0;
      follow_fails = '0;
      dock_fails = '0;
      seg_at = '0;
      seg_goal = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass on reset defaults
      queue_step(CMD_TICK, 1'b0, 1'b1);                     // idle, no area set up
      queue_event(CMD_COVER, 0, 1'b1, 1'b1, 5);             // reply with nothing pending
      queue_step(CMD_NAV, 1'b1, 1'b1);                      // stale navigate outcome
      queue_step(CMD_FOLLOW, 1'b1, 1'b1);                   // stale follow outcome
      queue_step(CMD_RETRY, 1'b1, 1'b1);                    // timer outside active states
      queue_step(CMD_DOCK, 1'b0, 1'b1);                     // dock failure while idle
      queue_event(CMD_BATTERY, 127, 1'b0, 1'b0, 0);
      queue_step(CMD_START, 1'b0, 1'b0);                    // coverage server down
      queue_step(CMD_START, 1'b1, 1'b1);                    // rejected outside idle/error
      queue_step(CMD_TICK, 1'b0, 1'b1);
      queue_event(CMD_COVER, 127, 1'b1, 1'b1, 0);           // zero segments
      queue_step(CMD_START, 1'b0, 1'b1);
      queue_event(CMD_COVER, 0, 1'b1, 1'b1, 255);
      queue_step(CMD_NAV, 1'b0, 1'b0);
      queue_step(CMD_RETRY, 1'b0, 1'b1);
      queue_step(CMD_NAV, 1'b1, 1'b1);
      queue_step(CMD_FOLLOW, 1'b0, 1'b1);
      queue_step(CMD_FOLLOW, 1'b1, 1'b1);
      queue_event(CMD_BATTERY, 0, 1'b1, 1'b1, 255);
      queue_step(CMD_TICK, 1'b1, 1'b0);                     // low battery, dock server down
      queue_step(CMD_START, 1'b1, 1'b1);
      queue_event(CMD_COVER, 0, 1'b0, 1'b1, 9);             // rejected coverage reply
      queue_step(CMD_DOCK, 1'b1, 1'b0);                     // dock success from any state
      queue_event(CMD_BATTERY, 127, 1'b0, 1'b1, 0);
      queue_step(CMD_TICK, 1'b0, 1'b1);
      drain();

      run_phase(30, 95, 1'b1, 1'b1, 3, 30, 1'b0);
      run_phase(0, 0, 1'b0, 1'b1, 0, 0, 1'b0);
      run_phase(100, 100, 1'b1, 1'b1, 15, 30, 1'b0);
      run_phase(50, 60, 1'b1, 1'b0, 1, 30, 1'b1);
      run_phase(20, 90, 1'b1, 1'b1, 2, 0, 1'b0);
      run_phase(40, 80, 1'b0, 1'b0, 7, 50, 1'b0);
      run_phase(25, 100, 1'b1, 1'b1, 15, 30, 1'b0);
      repeat (10) @(negedge clock);

      $display("checked %0d results from %0d events over %0d register settings",
               reports_checked, events_taken, settings_run + 1);
      $display("results per state idle..error: %0d %0d %0d %0d %0d %0d %0d", mode_seen[0],
               mode_seen[1], mode_seen[2], mode_seen[3], mode_seen[4], mode_seen[5], mode_seen[6]);
      if (fault_count == 0 && predicted_reports.size() == 0) begin
         $display("mission_sequencer_with_retries_unit_test: clean");
      end else begin
         $display("mission_sequencer_with_retries_unit_test: errors");
      end
      $finish;
   end

endmodule

// ===== mission_sequencer_with_retries_unit.f =====
+incdir+sv
sv/msr_pkg.sv
sv/msr_csr.sv
sv/msr_step.sv
sv/mission_sequencer_with_retries_unit.sv
verif/mission_sequencer_with_retries_unit_test.sv
